// ----- design/crs_pkg.sv -----
// crs_pkg: shared types, constants and float rounding helper for the scissor clamp
// depends on nothing
package crs_pkg;

  localparam int unsigned FloatW = 32;
  localparam int unsigned PixW   = 16;
  localparam int unsigned IntW   = 31;  // signed rounded value, |v| <= 1e9 + 1

  localparam logic [31:0] ExpMask   = 32'h7F80_0000;
  localparam logic [31:0] AbsMask   = 32'h7FFF_FFFF;
  localparam logic [31:0] Limit1e9  = 32'h4E6E_6B28;

  localparam int unsigned CfgIdxBits = 1;
  localparam logic [CfgIdxBits-1:0] RegPassWidth  = 1'b0;
  localparam logic [CfgIdxBits-1:0] RegPassHeight = 1'b1;

  typedef struct packed {
    logic [FloatW-1:0] left_bits;
    logic [FloatW-1:0] top_bits;
    logic [FloatW-1:0] right_bits;
    logic [FloatW-1:0] bottom_bits;
  } clip_t;

  typedef struct packed {
    logic            rect_valid;
    logic [PixW-1:0] origin_x;
    logic [PixW-1:0] origin_y;
    logic [PixW-1:0] span_x;
    logic [PixW-1:0] span_y;
  } scissor_t;

  typedef struct packed {
    logic [PixW-1:0] pass_width;
    logic [PixW-1:0] pass_height;
  } extent_t;

  // floor or ceil of a finite binary32 with magnitude at most 1e9
  function automatic logic signed [IntW-1:0] round_bits(input logic [31:0] bits,
                                                        input logic want_ceil);
    logic        neg;
    logic [7:0]  ef;
    logic [23:0] m;
    logic [IntW-1:0] ip;
    logic        has_frac;
    logic [4:0]  sh;
    logic [23:0] lowmask;
    neg = bits[31];
    ef  = bits[30:23];
    m   = {1'b1, bits[22:0]};
    ip  = '0;
    has_frac = 1'b0;
    sh = '0;
    lowmask = '0;
    if (ef == 8'd0) begin
      has_frac = (bits[22:0] != '0);
    end else if (ef >= 8'd150) begin
      ip = IntW'({7'd0, m} << (ef - 8'd150));
    end else if (ef < 8'd127) begin
      has_frac = 1'b1;
    end else begin
      sh = 5'(8'd150 - ef);
      ip = IntW'(m >> sh);
      lowmask = (24'd1 << sh) - 24'd1;
      has_frac = ((m & lowmask) != '0);
    end
    if (!neg) begin
      round_bits = (want_ceil && has_frac) ? signed'(ip + 1'b1) : signed'(ip);
    end else begin
      round_bits = (!want_ceil && has_frac) ? -signed'(ip + 1'b1) : -signed'(ip);
    end
  endfunction

endpackage

// ----- design/crs_if.sv -----
// crs_if: valid/ready channel interfaces for clip, scissor and config transactions
// depends on crs_pkg
interface crs_clip_if;
  logic          valid;
  logic          ready;
  crs_pkg::clip_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface crs_rect_if;
  logic             valid;
  logic             ready;
  crs_pkg::scissor_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface crs_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [crs_pkg::CfgIdxBits-1:0]       index;
  logic [crs_pkg::PixW-1:0]             wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ----- design/clip_rect_to_scissor_core.sv -----
// clip_rect_to_scissor_core: top level of the clip rectangle to scissor clamp
// depends on crs_pkg, crs_if, crs_regs, crs_calc
//
//  channel | dir | payload
//  clip    | in  | left/top/right/bottom binary32 patterns
//  rect    | out | rect_valid, origin_x/y, span_x/y
//  cfg     | in  | index (0 width, 1 height), wdata
//
// one transaction per cycle while the output is not stalled; input register, then result register
// the rounding and clamp sit between the two registers
// reset clears valid flags and the extent to zero
// a stalled result holds; the input stage keeps accepting while the output can drain
module clip_rect_to_scissor_core (
  input  logic    clk_i,
  input  logic    rst_ni,
  crs_clip_if.sink  clip,
  crs_rect_if.source rect,
  crs_cfg_if.sink   cfg
);
  import crs_pkg::*;

  extent_t  extent;
  clip_t    in_q;
  logic     in_vld_q;
  scissor_t res_d, res_q;
  logic     out_vld_q;
  logic     adv;

  crs_regs u_regs (.clk_i, .rst_ni, .cfg(cfg), .extent_o(extent));
  crs_calc u_calc (.clip_i(in_q), .extent_i(extent), .rect_o(res_d));

  // stage moves when the result register is free or being taken
  assign adv        = !out_vld_q || rect.ready;
  assign clip.ready = adv || !in_vld_q;
  assign rect.valid = out_vld_q;
  assign rect.data  = res_q;

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (adv) out_vld_q <= in_vld_q;
      if (clip.ready) in_vld_q <= clip.valid;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (clip.ready && clip.valid) in_q <= clip.data;
    if (adv && in_vld_q) res_q <= res_d;
  end
endmodule

// ----- design/crs_regs.sv -----
// crs_regs: pass extent configuration registers
// depends on crs_pkg, crs_if
module crs_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  crs_cfg_if.sink        cfg,
  output crs_pkg::extent_t extent_o
);
  import crs_pkg::*;

  extent_t extent_q;

  assign cfg.ready = 1'b1;
  assign extent_o  = extent_q;

  // register writes, unknown index ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      extent_q <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        RegPassWidth:  extent_q.pass_width  <= cfg.wdata;
        RegPassHeight: extent_q.pass_height <= cfg.wdata;
        default: ;
      endcase
    end
  end
endmodule

// ----- design/crs_calc.sv -----
// crs_calc: combinational float decode, round, clamp and emptiness test
// depends on crs_pkg
module crs_calc (
  input  crs_pkg::clip_t   clip_i,
  input  crs_pkg::extent_t extent_i,
  output crs_pkg::scissor_t rect_o
);
  import crs_pkg::*;

  logic bad;
  logic signed [IntW-1:0] x0, y0, x1, y1;
  logic signed [IntW-1:0] cx0, cy0, cx1, cy1;
  logic signed [IntW-1:0] pw, ph;

  assign pw = signed'(IntW'(extent_i.pass_width));
  assign ph = signed'(IntW'(extent_i.pass_height));

  // rejection of non-finite, huge and zero extent cases
  always_comb begin
    bad = (extent_i.pass_width == '0) || (extent_i.pass_height == '0);
    for (int k = 0; k < 4; k++) begin
      if ((clip_i[k*32 +: 32] & ExpMask) == ExpMask) bad = 1'b1;
      if ((clip_i[k*32 +: 32] & AbsMask) > Limit1e9) bad = 1'b1;
    end
  end

  assign x0 = round_bits(clip_i.left_bits,   1'b0);
  assign y0 = round_bits(clip_i.top_bits,    1'b0);
  assign x1 = round_bits(clip_i.right_bits,  1'b1);
  assign y1 = round_bits(clip_i.bottom_bits, 1'b1);

  assign cx0 = (x0 < 0) ? '0 : x0;
  assign cy0 = (y0 < 0) ? '0 : y0;
  assign cx1 = (x1 > pw) ? pw : x1;
  assign cy1 = (y1 > ph) ? ph : y1;

  // result assembly, all zero when empty
  always_comb begin
    rect_o = '0;
    if (!bad && (cx1 > cx0) && (cy1 > cy0)) begin
      rect_o.rect_valid = 1'b1;
      rect_o.origin_x   = cx0[PixW-1:0];
      rect_o.origin_y   = cy0[PixW-1:0];
      rect_o.span_x     = PixW'(cx1 - cx0);
      rect_o.span_y     = PixW'(cy1 - cy0);
    end
  end
endmodule

// ----- design/crs_checker.sv -----
// crs_checker: port level assertions for the scissor clamp, bound to the top level
// depends on crs_pkg, clip_rect_to_scissor_core
module crs_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic clip_valid,
  input logic clip_ready,
  input logic rect_valid,
  input logic rect_ready,
  input crs_pkg::scissor_t rect_data
);
  import crs_pkg::*;

  // held result while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rect_valid && !rect_ready |=> rect_valid && $stable(rect_data))
    else $error("result changed under stall");

  // empty results carry zero fields
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rect_valid && !rect_data.rect_valid |->
      rect_data.origin_x == '0 && rect_data.origin_y == '0 &&
      rect_data.span_x == '0 && rect_data.span_y == '0)
    else $error("empty result with non-zero fields");

  // valid rectangles have area
  a_area: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rect_valid && rect_data.rect_valid |-> rect_data.span_x != '0 && rect_data.span_y != '0)
    else $error("valid rectangle with zero span");

  // accepted item shows up after the input and result registers when output stays free
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clip_valid && clip_ready && (!rect_valid || rect_ready) ##1 (!rect_valid || rect_ready)
      |=> rect_valid)
    else $error("result missing");
endmodule

bind clip_rect_to_scissor_core crs_checker u_crs_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .clip_valid(clip.valid), .clip_ready(clip.ready),
  .rect_valid(rect.valid), .rect_ready(rect.ready), .rect_data(rect.data)
);
